// ----- design/ppz_pkg.sv -----
// ----------------------------------------------------------------------------
// ppz_pkg: shared types and constants for the point projection core
// Configuration and queue item layouts, register indexes and the sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package ppz_pkg;

  // Frame store geometry
  localparam int STORE_DEPTH = 8192;
  localparam int STORE_AW    = 13;

  // Glyph held by a cleared frame entry, and the largest depth value
  localparam logic [7:0]  GLYPH_SPACE = 8'd32;
  localparam logic [23:0] DEPTH_MAX   = 24'hFFFFFF;

  // Request kinds
  localparam logic KIND_PLOT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_CAM_X   = 3'd0;
  localparam logic [2:0] REG_CAM_Y   = 3'd1;
  localparam logic [2:0] REG_CAM_Z   = 3'd2;
  localparam logic [2:0] REG_ANGLE_A = 3'd3;
  localparam logic [2:0] REG_ANGLE_B = 3'd4;
  localparam logic [2:0] REG_ANGLE_C = 3'd5;
  localparam logic [2:0] REG_FOV     = 3'd6;

  typedef struct packed {
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic [15:0]        angle_a;
    logic [15:0]        angle_b;
    logic [15:0]        angle_c;
    logic [7:0]         fov_scale;
  } ppz_cfg_t;

  // One request after the front end has classified it
  typedef struct packed {
    logic               kind;
    logic signed [10:0] di;
    logic signed [10:0] dj;
    logic signed [10:0] dk;
    logic [7:0]         glyph;
    logic [12:0]        pixel_index;
  } ppz_item_t;

  // First quarter of a sine wave in unsigned Q1.14
  localparam logic [14:0] QUARTER_SINE [33] = '{
    15'd0, 15'd804, 15'd1606, 15'd2404, 15'd3196, 15'd3981, 15'd4756,
    15'd5520, 15'd6270, 15'd7005, 15'd7723, 15'd8423, 15'd9102, 15'd9760,
    15'd10394, 15'd11003, 15'd11585, 15'd12140, 15'd12665, 15'd13160,
    15'd13623, 15'd14053, 15'd14449, 15'd14811, 15'd15137, 15'd15426,
    15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
    15'd16384
  };

  // Sine of an angle given as a fraction of a turn, 128 steps per turn
  function automatic logic signed [15:0] sine_q14(input logic [15:0] ang);
    logic [6:0]  stp;
    logic [5:0]  idx;
    logic [14:0] v;
    stp = ang[15:9];
    idx = stp[5] ? (6'd32 - {1'b0, stp[4:0]}) : {1'b0, stp[4:0]};
    v   = QUARTER_SINE[idx];
    sine_q14 = stp[6] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [15:0] cosine_q14(input logic [15:0] ang);
    cosine_q14 = sine_q14(ang + 16'h4000);
  endfunction

endpackage

`default_nettype wire

// ----- design/ppz_ram.sv -----
// ----------------------------------------------------------------------------
// ppz_ram: generic single write, single read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ppz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/ppz_front.sv -----
// ----------------------------------------------------------------------------
// ppz_front: request intake
// Accepts requests, subtracts the camera and scales to whole units.
// ----------------------------------------------------------------------------
`default_nettype none

module ppz_front
  import ppz_pkg::*;
(
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire ppz_cfg_t    cfg,
  input  wire logic        enable,
  input  wire logic        q_full,
  output logic             push,
  output ppz_item_t        item
);

  // Difference to the camera, divided by 64 with truncation toward zero
  function automatic logic signed [10:0] to_unit(input logic signed [15:0] p,
                                                 input logic signed [15:0] c);
    logic signed [16:0] d;
    logic signed [16:0] b;
    d = 17'(p) - 17'(c);
    b = d[16] ? 17'sd63 : 17'sd0;
    to_unit = 11'((d + b) >>> 6);
  endfunction

  assign s_tready = enable && !q_full;
  assign push     = s_tvalid && s_tready;

  // Classify the request and prepare its payload for the back end
  always_comb begin
    item.kind        = s_tuser;
    item.di          = to_unit(s_tdata[15:0], cfg.cam_x);
    item.dj          = to_unit(s_tdata[31:16], cfg.cam_y);
    item.dk          = to_unit(s_tdata[47:32], cfg.cam_z);
    item.glyph       = s_tdata[55:48];
    item.pixel_index = s_tdata[68:56];
  end

endmodule

`default_nettype wire

// ----- design/ppz_queue.sv -----
// ----------------------------------------------------------------------------
// ppz_queue: two-entry request queue
// Decouples the intake from the projection engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ppz_queue
  import ppz_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire ppz_item_t din,
  input  wire logic      pop,
  output ppz_item_t      dout,
  output logic           full,
  output logic           nonempty
);

  ppz_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign dout     = slots[rd_ptr];

  // Pointer and occupancy control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- design/ppz_back.sv -----
// ----------------------------------------------------------------------------
// ppz_back: projection engine and frame store
// Rotates, divides, projects and depth-tests a plot request, or reads one frame entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ppz_back
  import ppz_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ppz_cfg_t  cfg,
  input  wire ppz_item_t q_item,
  input  wire logic      q_nonempty,
  output logic           q_pop,
  output logic           clear_done,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  output logic [31:0]    m_tdata,  // pixel_glyph [7:0], pixel_depth [31:8]
  output logic           m_tuser   // drawn
);

  localparam int CW     = $clog2(SCREEN_W);
  localparam int RW     = $clog2(SCREEN_H);
  localparam int PID_W  = CW + RW;
  localparam logic signed [63:0] HALF_W_T = 64'(SCREEN_W / 2) << 38;
  localparam logic signed [63:0] HALF_H_T = 64'(SCREEN_H / 2) << 38;
  localparam logic signed [25:0] COL_MAX  = 26'(SCREEN_W - 1);
  localparam logic signed [25:0] ROW_MAX  = 26'(SCREEN_H - 1);
  localparam logic signed [33:0] Z_SAT    = 34'sd16384;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_MUL   = 13'b0000000000100,
    S_ACC   = 13'b0000000001000,
    S_ZTEST = 13'b0000000010000,
    S_DIV   = 13'b0000000100000,
    S_PMUL  = 13'b0000001000000,
    S_PACC  = 13'b0000010000000,
    S_COORD = 13'b0000100000000,
    S_ADDR  = 13'b0001000000000,
    S_RD    = 13'b0010000000000,
    S_CHECK = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  ppz_item_t item;
  logic [3:0] step;
  logic [4:0] div_cnt;
  logic [STORE_AW-1:0] clr_cnt;
  logic [STORE_AW-1:0] addr;
  logic signed [31:0] u, v, p1, p2, p3, p4;
  logic signed [63:0] xa, ya, za;
  logic signed [33:0] x14, y14, z14;
  logic [33:0] rem;
  logic [23:0] depth;
  logic signed [33:0] depthf;
  logic signed [63:0] colp, rowp;
  logic signed [25:0] col, row;
  logic res_drawn;
  logic [7:0] res_glyph;
  logic [23:0] res_depth;

  // Shared multiplier
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod;

  // Frame store port signals
  logic we;
  logic [STORE_AW-1:0] waddr;
  logic [31:0] wdata, rdata;

  logic signed [15:0] sa, ca, sb, cb, sc, cc;

  // Truncating shifts toward zero
  function automatic logic signed [33:0] trunc28(input logic signed [63:0] x);
    logic signed [63:0] b;
    b = x[63] ? 64'sd268435455 : 64'sd0;
    trunc28 = 34'((x + b) >>> 28);
  endfunction

  function automatic logic signed [25:0] trunc38(input logic signed [63:0] x);
    logic signed [63:0] b;
    b = x[63] ? 64'sd274877906943 : 64'sd0;
    trunc38 = 26'((x + b) >>> 38);
  endfunction

  assign sa = sine_q14(cfg.angle_a);
  assign ca = cosine_q14(cfg.angle_a);
  assign sb = sine_q14(cfg.angle_b);
  assign cb = cosine_q14(cfg.angle_b);
  assign sc = sine_q14(cfg.angle_c);
  assign cc = cosine_q14(cfg.angle_c);

  assign clear_done = (state != S_CLEAR);
  assign q_pop      = (state == S_IDLE) && q_nonempty;

  // Operand selection for the rotation and projection sequences
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_PMUL) begin
      unique case (step)
        4'd0:    begin op_a = 34'({10'd0, depth}); op_b = 34'({26'd0, cfg.fov_scale}); end
        4'd1:    begin op_a = x14; op_b = depthf; end
        default: begin op_a = y14; op_b = depthf; end
      endcase
    end else begin
      unique case (step)
        4'd0:  begin op_a = 34'(item.dj); op_b = 34'(sa); end
        4'd1:  begin op_a = 34'(item.dk); op_b = 34'(ca); end
        4'd2:  begin op_a = 34'(item.dj); op_b = 34'(ca); end
        4'd3:  begin op_a = 34'(item.dk); op_b = 34'(sa); end
        4'd4:  begin op_a = 34'(sb); op_b = 34'(cc); end
        4'd5:  begin op_a = 34'(cb); op_b = 34'(cc); end
        4'd6:  begin op_a = 34'(sb); op_b = 34'(sc); end
        4'd7:  begin op_a = 34'(cb); op_b = 34'(sc); end
        4'd8:  begin op_a = 34'(p1); op_b = 34'(u); end
        4'd9:  begin op_a = 34'(sc); op_b = 34'(v); end
        4'd10: begin op_a = 34'(item.di); op_b = 34'(p2); end
        4'd11: begin op_a = 34'(cc); op_b = 34'(v); end
        4'd12: begin op_a = 34'(item.di); op_b = 34'(p4); end
        4'd13: begin op_a = 34'(p3); op_b = 34'(u); end
        4'd14: begin op_a = 34'(cb); op_b = 34'(u); end
        default: begin op_a = 34'(item.di); op_b = 34'(sb); end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Scaled and signed term for the accumulate step
  logic signed [63:0] term_sh, term;
  logic term_neg;
  always_comb begin
    unique case (step)
      4'd9, 4'd10, 4'd11, 4'd12, 4'd14: term_sh = prod[63:0] <<< 14;
      4'd15:                            term_sh = prod[63:0] <<< 28;
      default:                          term_sh = prod[63:0];
    endcase
    term_neg = (step == 4'd1) || (step == 4'd12) || (step == 4'd13) || (step == 4'd14);
    term     = term_neg ? -term_sh : term_sh;
  end

  // Truncated z for the z test, and one division step
  logic signed [33:0] z14_c;
  logic [33:0] rem2;
  logic div_ge;
  assign z14_c  = trunc28(za);
  assign rem2   = {rem[32:0], 1'b0};
  assign div_ge = (rem2 >= 34'(z14));

  // Pixel index and visibility
  logic [PID_W-1:0] pid;
  logic in_view;
  assign pid = PID_W'(col[CW-1:0]) + PID_W'(row[RW-1:0]) * PID_W'(SCREEN_W);
  assign in_view = (col >= 26'sd1) && (col <= COL_MAX) && (row >= 26'sd0) &&
                   (row <= ROW_MAX) && (32'(pid) < STORE_DEPTH);

  // Frame store write control
  logic win;
  assign win = (depth > rdata[23:0]);
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {GLYPH_SPACE, 24'd0};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (state == S_CHECK) begin
      if (item.kind == KIND_READ) begin
        we = 1'b1;
      end else if (win) begin
        we    = 1'b1;
        wdata = {item.glyph, depth};
      end
    end
  end

  ppz_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Result valid is raised when a result is loaded and dropped once taken
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + STORE_AW'(1);
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_nonempty) begin
            item      <= q_item;
            step      <= '0;
            u <= '0; v <= '0; p1 <= '0; p2 <= '0; p3 <= '0; p4 <= '0;
            xa <= '0; ya <= '0; za <= '0;
            res_drawn <= 1'b0;
            res_glyph <= '0;
            res_depth <= '0;
            addr      <= q_item.pixel_index;
            state     <= (q_item.kind == KIND_READ) ? S_RD : S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          unique case (step)
            4'd0, 4'd1:        u  <= u + term[31:0];
            4'd2, 4'd3:        v  <= v + term[31:0];
            4'd4:              p1 <= p1 + term[31:0];
            4'd5:              p2 <= p2 + term[31:0];
            4'd6:              p3 <= p3 + term[31:0];
            4'd7:              p4 <= p4 + term[31:0];
            4'd8, 4'd9, 4'd10: xa <= xa + term;
            4'd11, 4'd12, 4'd13: ya <= ya + term;
            default:           za <= za + term;
          endcase
          step  <= step + 4'd1;
          state <= (step == 4'd15) ? S_ZTEST : S_MUL;
        end
        S_ZTEST: begin
          x14 <= trunc28(xa);
          y14 <= trunc28(ya);
          z14 <= z14_c;
          step <= '0;
          if (za <= 64'sd0) begin
            state <= S_DONE;
          end else if (z14_c <= Z_SAT) begin
            depth <= DEPTH_MAX;
            state <= S_PMUL;
          end else begin
            rem     <= 34'd16384;
            depth   <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= div_ge ? (rem2 - 34'(z14)) : rem2;
          depth   <= {depth[22:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd23) begin
            state <= S_PMUL;
          end
        end
        S_PMUL: state <= S_PACC;
        S_PACC: begin
          unique case (step)
            4'd0:    depthf <= prod[33:0];
            4'd1:    colp   <= prod[63:0];
            default: rowp   <= prod[63:0];
          endcase
          step  <= step + 4'd1;
          state <= (step == 4'd2) ? S_COORD : S_PMUL;
        end
        S_COORD: begin
          col   <= trunc38(HALF_W_T - (colp <<< 1));
          row   <= trunc38(HALF_H_T - rowp);
          state <= S_ADDR;
        end
        S_ADDR: begin
          addr  <= STORE_AW'(pid);
          state <= in_view ? S_RD : S_DONE;
        end
        S_RD: state <= S_CHECK;
        S_CHECK: begin
          if (item.kind == KIND_READ) begin
            res_glyph <= rdata[31:24];
            res_depth <= rdata[23:0];
          end else begin
            res_drawn <= win;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res_depth, res_glyph};
            m_tuser  <= res_drawn;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/point_project_zbuffer_core.sv -----
// ----------------------------------------------------------------------------
// point_project_zbuffer_core: perspective point projection with a depth buffer
// Configuration registers, request intake, queue and projection engine.
// ----------------------------------------------------------------------------
// A read request passes from the queue through the frame store read and check states to its result.
// A plot request is sequenced through the shared multiplier (16 rotation products) and,
// when the reciprocal is computed, the bit-serial divider.
// One request is processed at a time; two more can wait in the queue.
// After reset every frame store entry is cleared before requests are taken.
`default_nettype none

module point_project_zbuffer_core
  import ppz_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // point_x [15:0], point_y [31:16], point_z [47:32], glyph [55:48],
  // pixel_index [68:56], zero [71:69]
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tuser,   // kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // pixel_glyph [7:0], pixel_depth [31:8]
  output logic             m_tuser,   // drawn
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ppz_cfg_t  cfg;
  ppz_item_t f_item, q_item;
  logic push, pop, q_full, q_nonempty, clear_done;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x     <= '0;
      cfg.cam_y     <= '0;
      cfg.cam_z     <= -16'sd3200;
      cfg.angle_a   <= '0;
      cfg.angle_b   <= '0;
      cfg.angle_c   <= '0;
      cfg.fov_scale <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CAM_X:   cfg.cam_x     <= cfg_data;
        REG_CAM_Y:   cfg.cam_y     <= cfg_data;
        REG_CAM_Z:   cfg.cam_z     <= cfg_data;
        REG_ANGLE_A: cfg.angle_a   <= cfg_data;
        REG_ANGLE_B: cfg.angle_b   <= cfg_data;
        REG_ANGLE_C: cfg.angle_c   <= cfg_data;
        REG_FOV:     cfg.fov_scale <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ppz_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .enable   (clear_done),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  ppz_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (f_item),
    .pop      (pop),
    .dout     (q_item),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  ppz_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_item     (q_item),
    .q_nonempty (q_nonempty),
    .q_pop      (pop),
    .clear_done (clear_done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire
